[sv/bthvac_pkg.sv]
package bthvac_pkg;

  // wide fixed-point word, Q16.16 with headroom
  localparam int FX_W = 48;
  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_LIM   = 48'sh3FFF_FFFF_FFFF;
  localparam fx_t FX_ONE   = 48'sd65536;
  localparam fx_t EXP_CUT  = 48'sd786432;
  localparam fx_t S32_MAX  = 48'sd2147483647;
  localparam fx_t S32_MIN  = -48'sd2147483648;
  localparam logic [19:0] LN2_FX  = 20'd45426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // shared unit operations
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_FMUL,
    ALU_FDIV,
    ALU_MULQ30,
    ALU_UDIV
  } alu_op_t;

  // configuration register indexes
  localparam logic [2:0] REG_LOSS     = 3'd0;
  localparam logic [2:0] REG_GAIN     = 3'd1;
  localparam logic [2:0] REG_CAP      = 3'd2;
  localparam logic [2:0] REG_SETPOINT = 3'd3;
  localparam logic [2:0] REG_INITIAL  = 3'd4;
  localparam logic [2:0] REG_COP_HEAT = 3'd5;
  localparam logic [2:0] REG_COP_COOL = 3'd6;
  localparam logic [2:0] REG_PLIMIT   = 3'd7;

  // reset values
  localparam logic [30:0]        RST_LOSS     = 31'd65536;
  localparam logic [30:0]        RST_GAIN     = 31'd65536;
  localparam logic [30:0]        RST_CAP      = 31'd65536;
  localparam logic signed [31:0] RST_SETPOINT = 32'sd1310720;
  localparam logic signed [31:0] RST_INITIAL  = 32'sd1310720;
  localparam logic [30:0]        RST_COP      = 31'd196608;
  localparam logic [30:0]        RST_PLIMIT   = 31'd65536000;

  typedef struct packed {
    logic [30:0]        loss_conductance;
    logic [30:0]        control_gain;
    logic [30:0]        heat_capacity;
    logic signed [31:0] setpoint_temp;
    logic signed [31:0] initial_temp;
    logic [30:0]        cop_heating;
    logic [30:0]        cop_cooling;
    logic [30:0]        power_limit;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [15:0]        dt_seconds;
    logic signed [31:0] gain_prev;
    logic signed [31:0] gain_now;
    logic signed [31:0] outside_prev;
    logic signed [31:0] outside_now;
  } item_t;

  typedef struct packed {
    logic signed [31:0] building_temp;
    logic signed [31:0] heat_added;
    logic [30:0]        electric_power;
    logic               heating;
    logic               at_limit;
  } res_t;

  // clamp a wide word to 32 bit signed
  function automatic logic signed [31:0] sat32(input fx_t v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic fx_t sx32(input logic signed [31:0] v);
    return FX_W'(v);
  endfunction

  function automatic fx_t ux31(input logic [30:0] v);
    return {17'b0, v};
  endfunction

endpackage

[sv/bthvac_alu.sv]
module bthvac_alu
  import bthvac_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req,
  input  alu_op_t op,
  input  fx_t     a,
  input  fx_t     b,
  output logic    done,
  output fx_t     result
);

  localparam int ACC_W = 2 * FX_W;
  localparam int DQ_W  = 64;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_WRAP, A_DONE} astate_t;

  astate_t             state;
  alu_op_t             op_r;
  logic [FX_W-1:0]     ua;
  logic [FX_W-1:0]     ub_sh;
  logic                neg;
  logic                a_neg;
  logic                a_zero;
  logic                b_zero;
  logic [ACC_W-1:0]    acc;
  logic [DQ_W-1:0]     dq;
  logic [FX_W-1:0]     rem;
  logic [6:0]          cnt;

  logic [FX_W-1:0]     a_mag;
  logic [FX_W-1:0]     b_mag;
  logic signed [FX_W:0] sum;
  fx_t                 add_res;
  logic [FX_W+15:0]    pp;
  logic [ACC_W-1:0]    acc_next;
  logic [FX_W:0]       trial;
  logic                qbit;
  logic [ACC_W-17:0]   m_hi;
  fx_t                 mul_mag;
  fx_t                 div_mag;

  localparam logic signed [FX_W:0] LIM_X = (FX_W+1)'(FX_LIM);

  // operand magnitudes and saturating add or subtract
  always_comb begin
    a_mag = a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
    b_mag = b[FX_W-1] ? FX_W'(-b) : FX_W'(b);
    if (op == ALU_SUB) begin
      sum = {a[FX_W-1], a} - {b[FX_W-1], b};
    end else begin
      sum = {a[FX_W-1], a} + {b[FX_W-1], b};
    end
    if (sum > LIM_X) begin
      add_res = FX_LIM;
    end else if (sum < -LIM_X) begin
      add_res = -FX_LIM;
    end else begin
      add_res = sum[FX_W-1:0];
    end
  end

  // one 48x16 partial product per cycle, high chunk first
  always_comb begin
    pp       = ua * ub_sh[FX_W-1:FX_W-16];
    acc_next = {acc[ACC_W-17:0], 16'b0} + {{(ACC_W-FX_W-16){1'b0}}, pp};
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    trial = {rem, dq[DQ_W-1]};
    qbit  = (trial >= {1'b0, ub_sh});
  end

  // result shaping
  always_comb begin
    m_hi = acc[ACC_W-1:16];
    if (m_hi > {{(ACC_W-16-FX_W){1'b0}}, FX_LIM}) begin
      mul_mag = FX_LIM;
    end else begin
      mul_mag = m_hi[FX_W-1:0];
    end
    if (dq > {{(DQ_W-FX_W){1'b0}}, FX_LIM}) begin
      div_mag = FX_LIM;
    end else begin
      div_mag = dq[FX_W-1:0];
    end
  end

  assign done = (state == A_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req) begin
            op_r   <= op;
            ua     <= a_mag;
            ub_sh  <= b_mag;
            neg    <= a[FX_W-1] ^ b[FX_W-1];
            a_neg  <= a[FX_W-1];
            a_zero <= (a == '0);
            b_zero <= (b == '0);
            acc    <= '0;
            rem    <= '0;
            case (op)
              ALU_ADD, ALU_SUB: begin
                result <= add_res;
                state  <= A_DONE;
              end
              ALU_FMUL, ALU_MULQ30: begin
                cnt   <= 7'd0;
                state <= A_MUL;
              end
              ALU_FDIV: begin
                dq    <= {a_mag, 16'b0};
                cnt   <= 7'd64;
                state <= A_DIV;
              end
              ALU_UDIV: begin
                dq    <= {a_mag[31:0], 32'b0};
                cnt   <= 7'd32;
                state <= A_DIV;
              end
              default: begin
                result <= '0;
                state  <= A_DONE;
              end
            endcase
          end
        end
        A_MUL: begin
          acc   <= acc_next;
          ub_sh <= {ub_sh[FX_W-17:0], 16'b0};
          cnt   <= cnt + 7'd1;
          if (cnt == 7'd2) begin
            state <= A_WRAP;
          end
        end
        A_DIV: begin
          dq  <= {dq[DQ_W-2:0], qbit};
          rem <= qbit ? FX_W'(trial - {1'b0, ub_sh}) : trial[FX_W-1:0];
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= A_WRAP;
          end
        end
        A_WRAP: begin
          case (op_r)
            ALU_FMUL:   result <= neg ? -mul_mag : mul_mag;
            ALU_MULQ30: result <= acc[FX_W+29:30];
            ALU_FDIV: begin
              if (b_zero) begin
                result <= a_zero ? '0 : (a_neg ? -FX_LIM : FX_LIM);
              end else begin
                result <= neg ? -div_mag : div_mag;
              end
            end
            ALU_UDIV:   result <= {16'b0, dq[31:0]};
            default:    result <= '0;
          endcase
          state <= A_DONE;
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  // done lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("alu done held for more than one cycle");

endmodule

[sv/bthvac_seq.sv]
module bthvac_seq
  import bthvac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  start,
  input  item_t item,
  input  logic  hold,
  output logic  busy,
  output logic  fin,
  output res_t  res
);

  typedef enum logic [5:0] {
    S_IDLE,
    S_KSUM, S_KDT, S_Z, S_DIFF, S_SCALE, S_RELAX,
    S_LY0, S_LY1, S_PSEL, S_PHI1, S_PHI2,
    S_P1A, S_P1B, S_P2A, S_P2B, S_P2C, S_P2D,
    S_C0, S_C1, S_C2, S_C3,
    S_B0, S_B1, S_B2, S_B3, S_B4,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
    S_OA, S_OB, S_OC, S_OD, S_OE, S_OF, S_OG, S_OH, S_OI, S_OJ,
    S_EXC, S_EXR, S_EXF, S_HMUL, S_HDIV,
    S_FIN
  } state_t;

  state_t             state;
  state_t             eret;
  state_t             hret;
  logic signed [31:0] temp;
  logic signed [31:0] hs;
  logic               maxed;
  logic [30:0]        ph;
  logic               heat;
  fx_t                dtq;
  logic signed [31:0] g0;
  logic signed [31:0] g1;
  logic signed [31:0] te0;
  logic signed [31:0] te1;
  fx_t                t;
  fx_t                u;
  fx_t                v;
  fx_t                y;
  fx_t                e;
  fx_t                phi1;
  fx_t                phi2;
  fx_t                c;
  logic [19:0]        r;
  logic [4:0]         k;
  logic [29:0]        x;
  logic [30:0]        p;
  logic [30:0]        q;
  logic [3:0]         n;
  logic [3:0]         nend;

  logic    alu_req;
  alu_op_t alu_op;
  fx_t     opa;
  fx_t     opb;
  logic    alu_done;
  fx_t     alu_res;

  fx_t         kb;
  fx_t         kc;
  fx_t         cb;
  fx_t         ts;
  fx_t         plim;
  fx_t         cop_now;
  fx_t         t_mag;
  logic [5:0]  sh;
  logic [31:0] rnd;
  logic [30:0] ph1_sum;
  logic [30:0] ph2_sum;

  bthvac_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .op     (alu_op),
    .a      (opa),
    .b      (opb),
    .done   (alu_done),
    .result (alu_res)
  );

  // widened configuration and helpers
  always_comb begin
    kb      = ux31(cfg.loss_conductance);
    kc      = ux31(cfg.control_gain);
    cb      = ux31(cfg.heat_capacity);
    ts      = sx32(cfg.setpoint_temp);
    plim    = ux31(cfg.power_limit);
    if (state == S_OH) begin
      cop_now = (t > 0) ? ux31(cfg.cop_heating) : ux31(cfg.cop_cooling);
    end else begin
      cop_now = heat ? ux31(cfg.cop_heating) : ux31(cfg.cop_cooling);
    end
    t_mag   = t[FX_W-1] ? -t : t;
    sh      = 6'd14 + {1'b0, k};
    rnd     = {1'b0, p} + (32'd1 << (sh - 6'd1));
    ph1_sum = p + 31'd8192;
    ph2_sum = {1'b0, p[30:1]} + 31'd8192;
  end

  // operation issued by each step
  always_comb begin
    alu_req = 1'b1;
    alu_op  = ALU_ADD;
    opa     = '0;
    opb     = '0;
    case (state)
      S_KSUM:  begin alu_op = ALU_ADD;  opa = kb;         opb = kc;         end
      S_KDT:   begin alu_op = ALU_FMUL; opa = t;          opb = dtq;        end
      S_Z:     begin alu_op = ALU_FDIV; opa = t;          opb = cb;         end
      S_DIFF:  begin alu_op = ALU_SUB;  opa = sx32(temp); opb = ts;         end
      S_SCALE: begin alu_op = ALU_FMUL; opa = e;          opb = t;          end
      S_RELAX: begin alu_op = ALU_ADD;  opa = ts;         opb = t;          end
      S_LY0:   begin alu_op = ALU_FMUL; opa = kb;         opb = dtq;        end
      S_LY1:   begin alu_op = ALU_FDIV; opa = y;          opb = cb;         end
      S_P1A:   begin alu_op = ALU_SUB;  opa = FX_ONE;     opb = e;          end
      S_P1B:   begin alu_op = ALU_FDIV; opa = u;          opb = y;          end
      S_P2A:   begin alu_op = ALU_SUB;  opa = e;          opb = FX_ONE;     end
      S_P2B:   begin alu_op = ALU_ADD;  opa = u;          opb = y;          end
      S_P2C:   begin alu_op = ALU_FMUL; opa = y;          opb = y;          end
      S_P2D:   begin alu_op = ALU_FDIV; opa = u;          opb = v;          end
      S_C0:    begin alu_op = ALU_FMUL; opa = kb;         opb = sx32(te0);  end
      S_C1:    begin alu_op = ALU_ADD;  opa = sx32(g0);   opb = u;          end
      S_C2:    begin alu_op = ALU_ADD;  opa = u;          opb = sx32(hs);   end
      S_C3:    begin alu_op = ALU_FDIV; opa = u;          opb = cb;         end
      S_B0:    begin alu_op = ALU_SUB;  opa = sx32(te1);  opb = sx32(te0);  end
      S_B1:    begin alu_op = ALU_FMUL; opa = kb;         opb = u;          end
      S_B2:    begin alu_op = ALU_SUB;  opa = sx32(g1);   opb = sx32(g0);   end
      S_B3:    begin alu_op = ALU_ADD;  opa = v;          opb = u;          end
      S_B4:    begin alu_op = ALU_FDIV; opa = u;          opb = cb;         end
      S_T0:    begin alu_op = ALU_FMUL; opa = sx32(temp); opb = e;          end
      S_T1:    begin alu_op = ALU_FMUL; opa = dtq;        opb = phi1;       end
      S_T2:    begin alu_op = ALU_FMUL; opa = u;          opb = c;          end
      S_T3:    begin alu_op = ALU_ADD;  opa = t;          opb = u;          end
      S_T4:    begin alu_op = ALU_FMUL; opa = dtq;        opb = phi2;       end
      S_T5:    begin alu_op = ALU_FMUL; opa = u;          opb = v;          end
      S_T6:    begin alu_op = ALU_ADD;  opa = t;          opb = u;          end
      S_OA:    begin alu_op = ALU_SUB;  opa = ts;         opb = sx32(te1);  end
      S_OB:    begin alu_op = ALU_FMUL; opa = kb;         opb = t;          end
      S_OC:    begin alu_op = ALU_SUB;  opa = '0;         opb = sx32(g1);   end
      S_OD:    begin alu_op = ALU_ADD;  opa = u;          opb = t;          end
      S_OE:    begin alu_op = ALU_SUB;  opa = ts;         opb = sx32(temp); end
      S_OF:    begin alu_op = ALU_FMUL; opa = kc;         opb = u;          end
      S_OG:    begin alu_op = ALU_ADD;  opa = t;          opb = u;          end
      S_OH:    begin alu_op = ALU_FDIV; opa = t_mag;      opb = cop_now;    end
      S_OJ:    begin alu_op = ALU_FMUL; opa = plim;       opb = cop_now;    end
      S_HMUL:  begin alu_op = ALU_MULQ30; opa = {18'b0, x}; opb = {17'b0, p}; end
      S_HDIV:  begin alu_op = ALU_UDIV;   opa = {17'b0, q}; opb = {44'b0, n}; end
      default: begin alu_req = 1'b0; end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign fin  = (state == S_FIN) && !hold;

  always_comb begin
    res.building_temp  = temp;
    res.heat_added     = hs;
    res.electric_power = ph;
    res.heating        = heat;
    res.at_limit       = maxed;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      temp  <= RST_INITIAL;
      hs    <= '0;
      maxed <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            dtq <= {16'b0, item.dt_seconds, 16'b0};
            g0  <= item.gain_prev;
            g1  <= item.gain_now;
            te0 <= item.outside_prev;
            te1 <= item.outside_now;
            if (!item.action) begin
              temp  <= cfg.initial_temp;
              state <= S_OA;
            end else if (!maxed) begin
              state <= S_KSUM;
            end else if (item.dt_seconds == '0) begin
              state <= S_OA;
            end else begin
              state <= S_LY0;
            end
          end
        end
        // relaxation toward the setpoint
        S_KSUM:  if (alu_done) begin t <= alu_res; state <= S_KDT; end
        S_KDT:   if (alu_done) begin t <= alu_res; state <= S_Z; end
        S_Z: begin
          if (alu_done) begin
            y     <= alu_res;
            eret  <= S_DIFF;
            state <= S_EXC;
          end
        end
        S_DIFF:  if (alu_done) begin t <= alu_res; state <= S_SCALE; end
        S_SCALE: if (alu_done) begin t <= alu_res; state <= S_RELAX; end
        S_RELAX: if (alu_done) begin temp <= sat32(alu_res); state <= S_OA; end
        // linear-forcing solution at the limit
        S_LY0:   if (alu_done) begin y <= alu_res; state <= S_LY1; end
        S_LY1: begin
          if (alu_done) begin
            y     <= alu_res;
            eret  <= S_PSEL;
            state <= S_EXC;
          end
        end
        S_PSEL: begin
          if (y < FX_ONE) begin
            x     <= {y[15:0], 14'b0};
            p     <= Q30_ONE;
            n     <= 4'd11;
            nend  <= 4'd2;
            hret  <= S_PHI1;
            state <= S_HMUL;
          end else begin
            state <= S_P1A;
          end
        end
        S_PHI1: begin
          phi1  <= {31'b0, ph1_sum[30:14]};
          p     <= Q30_ONE;
          n     <= 4'd12;
          nend  <= 4'd3;
          hret  <= S_PHI2;
          state <= S_HMUL;
        end
        S_PHI2: begin
          phi2  <= {31'b0, ph2_sum[30:14]};
          state <= S_C0;
        end
        S_P1A:   if (alu_done) begin u <= alu_res; state <= S_P1B; end
        S_P1B:   if (alu_done) begin phi1 <= alu_res; state <= S_P2A; end
        S_P2A:   if (alu_done) begin u <= alu_res; state <= S_P2B; end
        S_P2B:   if (alu_done) begin u <= alu_res; state <= S_P2C; end
        S_P2C:   if (alu_done) begin v <= alu_res; state <= S_P2D; end
        S_P2D:   if (alu_done) begin phi2 <= alu_res; state <= S_C0; end
        S_C0:    if (alu_done) begin u <= alu_res; state <= S_C1; end
        S_C1:    if (alu_done) begin u <= alu_res; state <= S_C2; end
        S_C2:    if (alu_done) begin u <= alu_res; state <= S_C3; end
        S_C3:    if (alu_done) begin c <= alu_res; state <= S_B0; end
        S_B0:    if (alu_done) begin u <= alu_res; state <= S_B1; end
        S_B1:    if (alu_done) begin u <= alu_res; state <= S_B2; end
        S_B2:    if (alu_done) begin v <= alu_res; state <= S_B3; end
        S_B3:    if (alu_done) begin u <= alu_res; state <= S_B4; end
        S_B4:    if (alu_done) begin v <= alu_res; state <= S_T0; end
        S_T0:    if (alu_done) begin t <= alu_res; state <= S_T1; end
        S_T1:    if (alu_done) begin u <= alu_res; state <= S_T2; end
        S_T2:    if (alu_done) begin u <= alu_res; state <= S_T3; end
        S_T3:    if (alu_done) begin t <= alu_res; state <= S_T4; end
        S_T4:    if (alu_done) begin u <= alu_res; state <= S_T5; end
        S_T5:    if (alu_done) begin u <= alu_res; state <= S_T6; end
        S_T6:    if (alu_done) begin temp <= sat32(alu_res); state <= S_OA; end
        // hvac demand, mode and power
        S_OA:    if (alu_done) begin t <= alu_res; state <= S_OB; end
        S_OB:    if (alu_done) begin t <= alu_res; state <= S_OC; end
        S_OC:    if (alu_done) begin u <= alu_res; state <= S_OD; end
        S_OD:    if (alu_done) begin t <= alu_res; state <= S_OE; end
        S_OE:    if (alu_done) begin u <= alu_res; state <= S_OF; end
        S_OF:    if (alu_done) begin u <= alu_res; state <= S_OG; end
        S_OG:    if (alu_done) begin t <= alu_res; state <= S_OH; end
        S_OH: begin
          if (alu_done) begin
            u     <= alu_res;
            heat  <= (t > 0);
            state <= S_OI;
          end
        end
        S_OI: begin
          if (u > plim) begin
            state <= S_OJ;
          end else begin
            maxed <= 1'b0;
            hs    <= sat32(t);
            ph    <= u[30:0];
            state <= S_FIN;
          end
        end
        S_OJ: begin
          if (alu_done) begin
            hs    <= sat32(heat ? alu_res : -alu_res);
            ph    <= cfg.power_limit;
            maxed <= 1'b1;
            state <= S_FIN;
          end
        end
        // exp(-y): range reduction by ln2, series, scale back
        S_EXC: begin
          if (y >= EXP_CUT) begin
            e     <= '0;
            state <= eret;
          end else begin
            r     <= y[FX_W-1] ? 20'd0 : y[19:0];
            k     <= 5'd0;
            state <= S_EXR;
          end
        end
        S_EXR: begin
          if (r >= LN2_FX) begin
            r <= r - LN2_FX;
            k <= k + 5'd1;
          end else begin
            x     <= {r[15:0], 14'b0};
            p     <= Q30_ONE;
            n     <= 4'd8;
            nend  <= 4'd1;
            hret  <= S_EXF;
            state <= S_HMUL;
          end
        end
        S_EXF: begin
          e     <= {16'b0, rnd >> sh};
          state <= eret;
        end
        // horner step: p = 1 - (x*p)/n in Q1.30
        S_HMUL:  if (alu_done) begin q <= alu_res[30:0]; state <= S_HDIV; end
        S_HDIV: begin
          if (alu_done) begin
            p <= Q30_ONE - alu_res[30:0];
            if (n == nend) begin
              state <= hret;
            end else begin
              n     <= n - 4'd1;
              state <= S_HMUL;
            end
          end
        end
        S_FIN: begin
          if (!hold) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // items only start from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("item started while busy");

  // ln2 reduction stays within the exp input range
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXR) |-> (k <= 5'd17))
    else $error("exp range reduction overran");

  // the shared unit only finishes an op still being requested
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> alu_req)
    else $error("alu finished without a request");

  // limit flag is only raised by the power clamp
  a_maxed_src: assert property (@(posedge clk) disable iff (rst)
    $rose(maxed) |-> ($past(state) == S_OJ))
    else $error("limit flag set outside the clamp step");

endmodule

[sv/building_thermal_hvac_step.sv]
// throughput: one item at a time, the next is taken the cycle after the result registers;
// the shared divider (Q16.16 quotients, series terms) dominates, above all in the exp and
// phi series; a stalled result holds off the next item
// reset: configuration returns to defaults, temperature 20.0, stored heat 0, not at limit
module building_thermal_hvac_step
  import bthvac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [15:0]        dt_seconds,
  input  logic signed [31:0] gain_prev,
  input  logic signed [31:0] gain_now,
  input  logic signed [31:0] outside_prev,
  input  logic signed [31:0] outside_now,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] building_temp,
  output logic signed [31:0] heat_added,
  output logic [30:0]        electric_power,
  output logic               heating,
  output logic               at_limit,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  start;
  logic  busy;
  logic  fin;
  logic  hold;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loss_conductance <= RST_LOSS;
      cfg.control_gain     <= RST_GAIN;
      cfg.heat_capacity    <= RST_CAP;
      cfg.setpoint_temp    <= RST_SETPOINT;
      cfg.initial_temp     <= RST_INITIAL;
      cfg.cop_heating      <= RST_COP;
      cfg.cop_cooling      <= RST_COP;
      cfg.power_limit      <= RST_PLIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOSS:     cfg.loss_conductance <= cfg_data[30:0];
        REG_GAIN:     cfg.control_gain     <= cfg_data[30:0];
        REG_CAP:      cfg.heat_capacity    <= cfg_data[30:0];
        REG_SETPOINT: cfg.setpoint_temp    <= cfg_data;
        REG_INITIAL:  cfg.initial_temp     <= cfg_data;
        REG_COP_HEAT: cfg.cop_heating      <= cfg_data[30:0];
        REG_COP_COOL: cfg.cop_cooling      <= cfg_data[30:0];
        REG_PLIMIT:   cfg.power_limit      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // input item
  always_comb begin
    item.action       = action;
    item.dt_seconds   = dt_seconds;
    item.gain_prev    = gain_prev;
    item.gain_now     = gain_now;
    item.outside_prev = outside_prev;
    item.outside_now  = outside_now;
  end

  assign in_stall = busy;
  assign start    = in_valid && !in_stall;
  assign hold     = out_valid && out_stall;

  bthvac_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (start),
    .item  (item),
    .hold  (hold),
    .busy  (busy),
    .fin   (fin),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      building_temp  <= res.building_temp;
      heat_added     <= res.heat_added;
      electric_power <= res.electric_power;
      heating        <= res.heating;
      at_limit       <= res.at_limit;
    end
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  import bthvac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIM   = 64'sh3FFF_FFFF_FFFF;
  localparam longint ONE   = 64'sd65536;
  localparam longint LN2   = 64'sd45426;
  localparam bit [63:0] Q30 = 64'h4000_0000;

  // thermal model scoreboard: predicts each result from the accepted item
  class hvac_scoreboard;
    longint loss, gain, cap, setp, init_t, cop_h, cop_c, plimit;
    longint temp_st, heat_st;
    bit     maxed;
    res_t   expected_results[$];
    int     errors;

    function new();
      loss = 65536; gain = 65536; cap = 65536;
      setp = 1310720; init_t = 1310720;
      cop_h = 196608; cop_c = 196608; plimit = 65536000;
      temp_st = init_t; heat_st = 0; maxed = 0; errors = 0;
    endfunction

    function longint sat(longint v);
      if (v > LIM) return LIM;
      if (v < -LIM) return -LIM;
      return v;
    endfunction

    function bit [63:0] mag(longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function longint fmul(longint a, longint b);
      bit [63:0] ua, ub, hi, lo, m;
      ua = mag(a); ub = mag(b); hi = ub >> 16; lo = ub & 64'hFFFF;
      if (hi != 0 && ua > 64'(LIM) / hi) m = LIM;
      else m = ua * hi + ((ua * lo) >> 16);
      if (m > 64'(LIM)) m = LIM;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint fdiv(longint a, longint b);
      bit [63:0] m;
      if (b == 0) return (a > 0) ? LIM : ((a < 0) ? -LIM : 0);
      m = (mag(a) << 16) / mag(b);
      if (m > 64'(LIM)) m = LIM;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // exp(-y) by range reduction and a short series
    function longint exp_neg(longint y);
      longint k, r;
      bit [63:0] r30, p;
      int sh;
      if (y < 0) y = 0;
      if (y >= 12 * ONE) return 0;
      k = y / LN2;
      r = y - k * LN2;
      r30 = 64'(r) << 14;
      p = Q30;
      for (int n = 8; n >= 1; n--) p = Q30 - ((r30 * p) >> 30) / 64'(n);
      sh = 14 + int'(k);
      return longint'((p + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function bit [63:0] series(bit [63:0] y30, int first, int last);
      bit [63:0] p;
      p = Q30;
      for (int m = last; m >= first; m--) p = Q30 - ((y30 * p) >> 30) / 64'(m);
      return p;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      longint u31, s32;
      u31 = longint'(data[30:0]);
      s32 = longint'(signed'(data));
      case (idx)
        REG_LOSS:     loss = u31;
        REG_GAIN:     gain = u31;
        REG_CAP:      cap = u31;
        REG_SETPOINT: setp = s32;
        REG_INITIAL:  init_t = s32;
        REG_COP_HEAT: cop_h = u31;
        REG_COP_COOL: cop_c = u31;
        REG_PLIMIT:   plimit = u31;
        default: ;
      endcase
    endfunction

    // linear-forcing solution used when the unit sat at its limit
    function longint limited_temp(longint dtq, longint g0, longint g1,
                                  longint te0, longint te1);
      longint y, e, phi1, phi2, c, bdt, t;
      bit [63:0] y30;
      if (dtq == 0) return temp_st;
      y = fdiv(fmul(loss, dtq), cap);
      e = exp_neg(y);
      if (y < ONE) begin
        y30 = 64'(y) << 14;
        phi1 = longint'((series(y30, 2, 11) + 64'd8192) >> 14);
        phi2 = longint'(((series(y30, 3, 12) >> 1) + 64'd8192) >> 14);
      end else begin
        phi1 = fdiv(ONE - e, y);
        phi2 = fdiv(sat(sat(e - ONE) + y), fmul(y, y));
      end
      c = fdiv(sat(sat(g0 + fmul(loss, te0)) + heat_st), cap);
      bdt = fdiv(sat(sat(g1 - g0) + fmul(loss, sat(te1 - te0))), cap);
      t = fmul(temp_st, e);
      t = sat(t + fmul(fmul(dtq, phi1), c));
      t = sat(t + fmul(fmul(dtq, phi2), bdt));
      return t;
    endfunction

    function void note_item(item_t it);
      longint dtq, g0, g1, te0, te1, z, t, dqh, cop, ph;
      bit heat_mode;
      res_t r;
      dtq = longint'(it.dt_seconds) << 16;
      g0 = longint'(it.gain_prev); g1 = longint'(it.gain_now);
      te0 = longint'(it.outside_prev); te1 = longint'(it.outside_now);
      if (!it.action) begin
        temp_st = init_t;
      end else begin
        if (!maxed) begin
          z = fdiv(fmul(sat(loss + gain), dtq), cap);
          t = sat(setp + fmul(exp_neg(z), sat(temp_st - setp)));
        end else begin
          t = limited_temp(dtq, g0, g1, te0, te1);
        end
        temp_st = clamp32(t);
      end
      // heat demand, mode and electrical power
      dqh = sat(sat(-g1 + fmul(loss, sat(setp - te1))) + fmul(gain, sat(setp - temp_st)));
      heat_mode = dqh > 0;
      cop = heat_mode ? cop_h : cop_c;
      ph = fdiv(longint'(mag(dqh)), cop);
      if (ph > plimit) begin
        ph = plimit;
        dqh = heat_mode ? fmul(ph, cop) : -fmul(ph, cop);
        maxed = 1;
      end else begin
        maxed = 0;
      end
      heat_st = clamp32(dqh);
      r.building_temp = temp_st[31:0];
      r.heat_added = heat_st[31:0];
      r.electric_power = ph[30:0];
      r.heating = heat_mode;
      r.at_limit = maxed;
      expected_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result", got.building_temp, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.building_temp !== want.building_temp)
        report("building_temp", got.building_temp, want.building_temp);
      if (got.heat_added !== want.heat_added)
        report("heat_added", got.heat_added, want.heat_added);
      if (got.electric_power !== want.electric_power)
        report("electric_power", 32'(got.electric_power), 32'(want.electric_power));
      if (got.heating !== want.heating)
        report("heating", 32'(got.heating), 32'(want.heating));
      if (got.at_limit !== want.at_limit)
        report("at_limit", 32'(got.at_limit), 32'(want.at_limit));
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic               action = 0;
  logic [15:0]        dt_seconds = 0;
  logic signed [31:0] gain_prev = 0;
  logic signed [31:0] gain_now = 0;
  logic signed [31:0] outside_prev = 0;
  logic signed [31:0] outside_now = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] building_temp;
  logic signed [31:0] heat_added;
  logic [30:0]        electric_power;
  logic               heating;
  logic               at_limit;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_LOSS;
  logic [31:0]        cfg_data = 0;

  hvac_scoreboard sb = new();
  bit quiet = 0;
  int items_sent = 0;

  building_thermal_hvac_step u_top (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  task write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task send_item(item_t it);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    action <= it.action;
    dt_seconds <= it.dt_seconds;
    gain_prev <= it.gain_prev;
    gain_now <= it.gain_now;
    outside_prev <= it.outside_prev;
    outside_now <= it.outside_now;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    items_sent++;
  endtask

  task drain();
    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function item_t mk(logic act, logic [15:0] dt, logic [31:0] gp, logic [31:0] gn,
                     logic [31:0] op, logic [31:0] on);
    item_t it;
    it.action = act; it.dt_seconds = dt;
    it.gain_prev = gp; it.gain_now = gn; it.outside_prev = op; it.outside_now = on;
    return it;
  endfunction

  // mostly plausible weather and loads, some full-range noise
  function item_t rand_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return mk(0, 16'($urandom), $urandom, $urandom, $urandom, $urandom);
    if (sel < 85)
      return mk(1, 16'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 3600)),
                $urandom_range(0, 5000 * 65536) - 2500 * 65536,
                $urandom_range(0, 5000 * 65536) - 2500 * 65536,
                $urandom_range(0, 85 * 65536) - 40 * 65536,
                $urandom_range(0, 85 * 65536) - 40 * 65536);
    return mk(1'($urandom), 16'($urandom), $urandom, $urandom, $urandom, $urandom);
  endfunction

  // configuration sets: realistic, extreme, tight power limit, zero divisors
  task set_config(int kind);
    case (kind)
      0: begin
        write_reg(REG_LOSS, $urandom_range(1, 500 * 65536));
        write_reg(REG_GAIN, $urandom_range(0, 2000 * 65536));
        write_reg(REG_CAP, $urandom_range(1, 32'h7FFF_FFFF));
        write_reg(REG_SETPOINT, $urandom_range(0, 30 * 65536));
        write_reg(REG_INITIAL, $urandom_range(0, 60 * 65536) - 20 * 65536);
        write_reg(REG_COP_HEAT, $urandom_range(65536, 6 * 65536));
        write_reg(REG_COP_COOL, $urandom_range(65536, 6 * 65536));
        write_reg(REG_PLIMIT, $urandom_range(0, 3000 * 65536));
      end
      1: begin
        write_reg(REG_LOSS, 32'h7FFF_FFFF);
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_CAP, 32'h7FFF_FFFF);
        write_reg(REG_SETPOINT, 32'h7FFF_FFFF);
        write_reg(REG_INITIAL, 32'h8000_0000);
        write_reg(REG_COP_HEAT, 32'h7FFF_FFFF);
        write_reg(REG_COP_COOL, 32'h7FFF_FFFF);
        write_reg(REG_PLIMIT, 32'h7FFF_FFFF);
      end
      2: begin
        write_reg(REG_LOSS, 1);
        write_reg(REG_GAIN, 0);
        write_reg(REG_CAP, 1);
        write_reg(REG_SETPOINT, 32'h8000_0000);
        write_reg(REG_INITIAL, 32'h7FFF_FFFF);
        write_reg(REG_COP_HEAT, 1);
        write_reg(REG_COP_COOL, 1);
        write_reg(REG_PLIMIT, 0);
      end
      3: begin
        write_reg(REG_LOSS, $urandom_range(1, 400 * 65536));
        write_reg(REG_GAIN, $urandom_range(0, 4000 * 65536));
        write_reg(REG_CAP, $urandom_range(65536, 32'h7FFF_FFFF));
        write_reg(REG_SETPOINT, $urandom_range(15 * 65536, 25 * 65536));
        write_reg(REG_INITIAL, $urandom_range(0, 40 * 65536));
        write_reg(REG_COP_HEAT, $urandom_range(65536, 4 * 65536));
        write_reg(REG_COP_COOL, $urandom_range(65536, 4 * 65536));
        write_reg(REG_PLIMIT, $urandom_range(0, 200 * 65536));
      end
      default: begin
        write_reg(REG_CAP, 0);
        write_reg(REG_COP_HEAT, 0);
        write_reg(REG_COP_COOL, 0);
        write_reg(REG_PLIMIT, $urandom_range(0, 100 * 65536));
        write_reg(REG_LOSS, $urandom);
        write_reg(REG_GAIN, $urandom);
        write_reg(REG_SETPOINT, $urandom);
        write_reg(REG_INITIAL, $urandom);
      end
    endcase
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset settings, field extremes, zero and longest steps
    send_item(mk(0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk(1, 0, 0, 0, 0, 0));
    send_item(mk(1, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(mk(1, 1, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000));
    send_item(mk(1, 600, 0, 0, 0, 0));
    drain();
    // power limit zero keeps the unit at its limit, including a zero step
    write_reg(REG_PLIMIT, 0);
    send_item(mk(0, 0, 0, 100 * 65536, 0, 0));
    send_item(mk(1, 0, 0, 100 * 65536, 0, 0));
    send_item(mk(1, 1, 500 * 65536, -500 * 65536, -10 * 65536, 30 * 65536));
    send_item(mk(1, 60, 0, 0, 5 * 65536, 5 * 65536));
    send_item(mk(1, 3600, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(mk(1, 16'hFFFF, -200 * 65536, 300 * 65536, 40 * 65536, -40 * 65536));
    drain();
    // zero divisors
    set_config(4);
    send_item(mk(0, 0, 65536, 65536, 65536, 65536));
    send_item(mk(1, 100, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 0));
    send_item(mk(1, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    drain();
    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      set_config(ph % 5);
      if (ph == 3) quiet = 1;
      repeat (115) send_item(rand_item());
      quiet = 0;
      drain();
    end
    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // result side stall, with one long hold-off after the first 200 items, which holds off the input too
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= 200) begin
        held = 1;
        hold = 4000;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{building_temp, heat_added, electric_power, heating, at_limit});
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
sv/bthvac_pkg.sv
sv/bthvac_alu.sv
sv/bthvac_seq.sv
sv/building_thermal_hvac_step.sv
dv/tb_top.sv
